// ----- rtl/bounded_deque_with_search_top_defines.svh -----
// Assertion helpers for the deque top-level RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BDQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
  } out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             shr;
    logic             shl;
    logic             wr;
    logic [31:0]      value;
    logic [CNT_W-1:0] occ;
  } cell_ctl_t;

  // search token walking down the chain
  typedef struct packed {
    logic        act;
    logic        hit;
    logic [3:0]  pos;
    logic [31:0] key;
  } token_t;

endpackage
`default_nettype wire

// ----- rtl/bdq_cell.sv -----
`default_nettype none
module bdq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  bdq_pkg::cell_ctl_t            ctl,
  input  logic [bdq_pkg::IDX_W-1:0]     idx,
  input  logic [31:0]                   left,
  input  logic [31:0]                   right,
  input  bdq_pkg::token_t               tok_in,
  output logic [31:0]                   data,
  output bdq_pkg::token_t               tok_out
);
  import bdq_pkg::*;

  logic match;
  logic here;

  assign here  = (CNT_W'(idx) == ctl.occ);
  assign match = tok_in.act && (CNT_W'(idx) < ctl.occ) && (data == tok_in.key);

  always_ff @(posedge clk) begin
    if (ctl.shr) begin
      data <= left;
    end else if (ctl.shl) begin
      data <= right;
    end else if (ctl.wr && here) begin
      data <= ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.act <= 1'b0;
    end else begin
      tok_out.act <= tok_in.act;
    end
    tok_out.hit <= tok_in.hit | match;
    tok_out.pos <= (!tok_in.hit && match) ? 4'(idx) : tok_in.pos;
    tok_out.key <= tok_in.key;
  end

endmodule
`default_nettype wire

// ----- rtl/bounded_deque_with_search_top.sv -----
// Deque of signed words in a row of DEPTH cells; position 0 sits in cell 0.
// Push and remove: result is registered and appears in the cycle after the input beat.
// Search: a token walks one cell per cycle; the result is registered as it leaves the last cell.
// Push/remove take one beat per cycle unless the output is stalled; a search stalls input until it is done.
// Synchronous active-high reset empties the deque; cell contents are not cleared.
`default_nettype none
`include "bounded_deque_with_search_top_defines.svh"
module bounded_deque_with_search_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             start;
  logic             imm_done;
  logic [1:0]       imm_status;
  cell_ctl_t        ctl;
  token_t           tok_head;
  logic [31:0]      cdata [DEPTH];
  token_t           ctok  [DEPTH];

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (occ == CNT_W'(DEPTH));
  assign empty    = (occ == '0);

  always_comb begin
    ctl.shr    = 1'b0;
    ctl.shl    = 1'b0;
    ctl.wr     = 1'b0;
    ctl.value  = in_data.value;
    ctl.occ    = occ;
    occ_next   = occ;
    start      = 1'b0;
    imm_done   = 1'b0;
    imm_status = ST_OK;
    state_next = state;
    if (accept) begin
      imm_done = 1'b1;
      case (in_data.action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            imm_status = ST_FULL;
          end else begin
            ctl.shr  = 1'b1;
            occ_next = occ + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            imm_status = ST_FULL;
          end else begin
            ctl.wr   = 1'b1;
            occ_next = occ + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            imm_status = ST_EMPTY;
          end else begin
            ctl.shl  = 1'b1;
            occ_next = occ - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            imm_status = ST_EMPTY;
          end else begin
            occ_next = occ - 1'b1;
          end
        end
        ACT_SEARCH: begin
          imm_done   = 1'b0;
          start      = 1'b1;
          state_next = S_BUSY;
        end
        default: begin
          imm_status = ST_OK;
        end
      endcase
    end
    if (state == S_BUSY && ctok[DEPTH-1].act) begin
      state_next = S_IDLE;
    end
  end

  assign tok_head.act = start;
  assign tok_head.hit = 1'b0;
  assign tok_head.pos = 4'd0;
  assign tok_head.key = in_data.key;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bdq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .idx     (IDX_W'(g)),
      .left    ((g == 0) ? in_data.value : cdata[(g == 0) ? 0 : g - 1]),
      .right   (cdata[(g == DEPTH - 1) ? g : g + 1]),
      .tok_in  ((g == 0) ? tok_head : ctok[(g == 0) ? 0 : g - 1]),
      .data    (cdata[g]),
      .tok_out (ctok[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_done || (state == S_BUSY && ctok[DEPTH-1].act)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_done) begin
      out_data.status   <= imm_status;
      out_data.position <= 4'd0;
    end else if (state == S_BUSY && ctok[DEPTH-1].act) begin
      out_data.status   <= ctok[DEPTH-1].hit ? ST_OK : ST_NOTFOUND;
      out_data.position <= ctok[DEPTH-1].hit ? ctok[DEPTH-1].pos : 4'd0;
    end
  end

  `BDQ_ASSERT_IMP(a_occ_bound, clk, rst, 1'b1, occ <= CNT_W'(DEPTH), "occupancy over depth")
  `BDQ_ASSERT_IMP(a_busy_stall, clk, rst, state == S_BUSY, in_stall, "beat taken during search")
  `BDQ_ASSERT_IMP(a_tok_busy, clk, rst, ctok[DEPTH-1].act, state == S_BUSY, "stray search token")
  `BDQ_ASSERT_NXT(a_srch_start, clk, rst, accept && in_data.action == ACT_SEARCH,
                  state == S_BUSY && occ == $past(occ), "search did not start")

endmodule
`default_nettype wire
